### rtl/ray_box_slab_entry_defines.svh
// Assertion macros used by rbs_checker.
// No dependencies.
`ifndef RAY_BOX_SLAB_ENTRY_DEFINES_SVH
`define RAY_BOX_SLAB_ENTRY_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define RBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rbs_pkg.sv
// Shared types and constants of the ray versus box slab test.
// No dependencies.
package rbs_pkg;

  localparam int POS_W  = 37;
  localparam int DIR_W  = 18;
  localparam int DIST_W = 36;
  localparam int FACE_W = 3;

  // Per item side data that travels along the divider stages.
  typedef struct packed {
    logic       valid;
    logic       zmiss;  // zero direction axis with origin outside its slab
    logic [2:0] dzero;  // direction is zero on this axis
    logic [2:0] dpos;   // direction is positive on this axis
    logic [5:0] qneg;   // quotient sign per lane, lane = 2*axis + high
  } rbs_side_t;

endpackage

### rtl/rbs_ifs.sv
// Valid/ready channel interfaces for ray items and hit results.
// Depends on rbs_pkg.
interface rbs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbs_pkg::POS_W-1:0]    box_low_x;
  logic signed [rbs_pkg::POS_W-1:0]    box_low_y;
  logic signed [rbs_pkg::POS_W-1:0]    box_low_z;
  logic signed [rbs_pkg::POS_W-1:0]    box_high_x;
  logic signed [rbs_pkg::POS_W-1:0]    box_high_y;
  logic signed [rbs_pkg::POS_W-1:0]    box_high_z;
  logic signed [rbs_pkg::POS_W-1:0]    origin_x;
  logic signed [rbs_pkg::POS_W-1:0]    origin_y;
  logic signed [rbs_pkg::POS_W-1:0]    origin_z;
  logic signed [rbs_pkg::DIR_W-1:0]    dir_x;
  logic signed [rbs_pkg::DIR_W-1:0]    dir_y;
  logic signed [rbs_pkg::DIR_W-1:0]    dir_z;

  modport source (output valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                  box_high_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                box_high_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [rbs_pkg::DIST_W-1:0]   entry_distance;
  logic [rbs_pkg::FACE_W-1:0]   entry_face;

  modport source (output valid, hit, entry_distance, entry_face, input ready);
  modport sink (input valid, hit, entry_distance, entry_face, output ready);
endinterface

### rtl/ray_box_slab_entry.sv
// Throughput: one item per cycle unless the output stalls; six restoring dividers, one quotient bit per stage.
// The whole pipeline holds while the output register holds an untaken result.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
// Depends on rbs_pkg and the rbs_in_if / rbs_out_if interfaces.
module ray_box_slab_entry #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  rbs_in_if.sink   in_ch,
  rbs_out_if.source out_ch
);

  localparam int PW = rbs_pkg::POS_W;
  localparam int DW = rbs_pkg::DIR_W;
  localparam int MW = PW + 1;           // magnitude of plane - origin
  localparam int NW = MW + FRAC_BITS;   // numerator bits = divider stages
  localparam int RW = DW + 1;           // partial remainder
  localparam int LW = RW + NW;          // {remainder, numerator/quotient}
  localparam int QW = NW + 1;           // signed quotient
  localparam int DSW = rbs_pkg::DIST_W;

  typedef logic [LW-1:0] lane_t;
  typedef logic signed [QW-1:0] quo_t;

  // Running latest entry / earliest exit across axes.
  typedef struct packed {
    logic       valid;
    logic       zmiss;
    logic [2:0] dpos;
    logic       near_ok;
    logic [1:0] axis;
    quo_t       near_t;
    logic       far_ok;
    quo_t       far_t;
  } comb_t;

  // One restoring step: shift, trial subtract, quotient bit into bit 0.
  function automatic lane_t div_step(lane_t x, logic [DW-1:0] d);
    lane_t           y;
    logic [RW-1:0]   r;
    y = x << 1;
    r = y[LW-1:NW];
    if (r >= {1'b0, d}) begin
      y[LW-1:NW] = r - {1'b0, d};
      y[0] = 1'b1;
    end
    return y;
  endfunction

  // Fold one axis into the running near/far pair; first axis wins ties.
  function automatic comb_t fold(comb_t c, logic use_ax, logic [1:0] ax, quo_t e, quo_t l);
    comb_t o;
    o = c;
    if (use_ax) begin
      if (!c.near_ok || e > c.near_t) begin
        o.near_t  = e;
        o.axis    = ax;
        o.near_ok = 1'b1;
      end
      if (!c.far_ok || l < c.far_t) begin
        o.far_t  = l;
        o.far_ok = 1'b1;
      end
    end
    return o;
  endfunction

  logic adv;
  logic out_valid_r;

  // Whole pipe moves when the output register is free or being taken.
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage A: differences, magnitudes, signs ----------------
  logic signed [PW-1:0] lo_w [3];
  logic signed [PW-1:0] hi_w [3];
  logic signed [PW-1:0] org_w [3];
  logic signed [DW-1:0] dir_w [3];

  assign lo_w[0]  = in_ch.box_low_x;
  assign lo_w[1]  = in_ch.box_low_y;
  assign lo_w[2]  = in_ch.box_low_z;
  assign hi_w[0]  = in_ch.box_high_x;
  assign hi_w[1]  = in_ch.box_high_y;
  assign hi_w[2]  = in_ch.box_high_z;
  assign org_w[0] = in_ch.origin_x;
  assign org_w[1] = in_ch.origin_y;
  assign org_w[2] = in_ch.origin_z;
  assign dir_w[0] = in_ch.dir_x;
  assign dir_w[1] = in_ch.dir_y;
  assign dir_w[2] = in_ch.dir_z;

  lane_t             lane_nxt [6];
  logic [DW-1:0]     dmag_nxt [3];
  rbs_pkg::rbs_side_t side_nxt;

  always_comb begin
    logic signed [MW-1:0] diff;
    logic [MW-1:0]        mag;
    side_nxt       = '0;
    side_nxt.valid = in_ch.valid;
    for (int a = 0; a < 3; a++) begin
      side_nxt.dzero[a] = (dir_w[a] == '0);
      side_nxt.dpos[a]  = !dir_w[a][DW-1] && (dir_w[a] != '0);
      if (side_nxt.dzero[a] && (org_w[a] < lo_w[a] || org_w[a] > hi_w[a])) begin
        side_nxt.zmiss = 1'b1;
      end
      dmag_nxt[a] = dir_w[a][DW-1] ? DW'(-dir_w[a]) : DW'(dir_w[a]);
      for (int h = 0; h < 2; h++) begin
        diff = (h == 0) ? (MW'(lo_w[a]) - MW'(org_w[a])) : (MW'(hi_w[a]) - MW'(org_w[a]));
        mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
        side_nxt.qneg[2*a+h] = diff[MW-1] ^ dir_w[a][DW-1];
        lane_nxt[2*a+h]      = {{RW{1'b0}}, mag, {FRAC_BITS{1'b0}}};
      end
    end
  end

  // ---------------- divider stages ----------------
  lane_t              lane_r [NW+1][6];
  logic [DW-1:0]      dmag_r [NW+1][3];
  rbs_pkg::rbs_side_t side_r [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NW; s++) begin
        side_r[s].valid <= 1'b0;
      end
    end else if (adv) begin
      lane_r[0] <= lane_nxt;
      dmag_r[0] <= dmag_nxt;
      side_r[0] <= side_nxt;
      for (int s = 0; s < NW; s++) begin
        for (int i = 0; i < 6; i++) begin
          lane_r[s+1][i] <= div_step(lane_r[s][i], dmag_r[s][i >> 1]);
        end
        dmag_r[s+1] <= dmag_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  // ---------------- stage C: apply quotient signs ----------------
  quo_t               q_r [6];
  rbs_pkg::rbs_side_t side_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c_r.valid <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < 6; i++) begin
        q_r[i] <= side_r[NW].qneg[i] ? -$signed({1'b0, lane_r[NW][i][NW-1:0]})
                                     : $signed({1'b0, lane_r[NW][i][NW-1:0]});
      end
      side_c_r <= side_r[NW];
    end
  end

  // ---------------- stage D: order entry/exit per axis ----------------
  quo_t               ent_r [3];
  quo_t               lev_r [3];
  rbs_pkg::rbs_side_t side_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_d_r.valid <= 1'b0;
    end else if (adv) begin
      for (int a = 0; a < 3; a++) begin
        if (q_r[2*a] > q_r[2*a+1]) begin
          ent_r[a] <= q_r[2*a+1];
          lev_r[a] <= q_r[2*a];
        end else begin
          ent_r[a] <= q_r[2*a];
          lev_r[a] <= q_r[2*a+1];
        end
      end
      side_d_r <= side_c_r;
    end
  end

  // ---------------- stage E: fold x and y; stage F: fold z ----------------
  comb_t comb_e_r, comb_f_r;
  quo_t  ent_z_r, lev_z_r;
  logic  use_z_r;
  comb_t comb_e_nxt;

  always_comb begin
    comb_e_nxt         = '0;
    comb_e_nxt.valid   = side_d_r.valid;
    comb_e_nxt.zmiss   = side_d_r.zmiss;
    comb_e_nxt.dpos    = side_d_r.dpos;
    comb_e_nxt = fold(comb_e_nxt, !side_d_r.dzero[0], 2'd0, ent_r[0], lev_r[0]);
    comb_e_nxt = fold(comb_e_nxt, !side_d_r.dzero[1], 2'd1, ent_r[1], lev_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comb_e_r.valid <= 1'b0;
      comb_f_r.valid <= 1'b0;
    end else if (adv) begin
      comb_e_r <= comb_e_nxt;
      ent_z_r  <= ent_r[2];
      lev_z_r  <= lev_r[2];
      use_z_r  <= !side_d_r.dzero[2];
      comb_f_r <= fold(comb_e_r, use_z_r, 2'd2, ent_z_r, lev_z_r);
    end
  end

  // ---------------- output register: miss test, clamp, face ----------------
  logic           hit_r;
  logic [DSW-1:0] dist_r;
  logic [2:0]     face_r;
  logic           miss_w;
  logic [DSW-1:0] dist_w;

  always_comb begin
    miss_w = comb_f_r.zmiss || !comb_f_r.near_ok || (comb_f_r.near_t > comb_f_r.far_t)
          || comb_f_r.far_t[QW-1];
    if (comb_f_r.near_t[QW-1]) begin
      dist_w = '0;
    end else if (comb_f_r.near_t > $signed({{(QW-DSW){1'b0}}, {DSW{1'b1}}})) begin
      dist_w = {DSW{1'b1}};
    end else begin
      dist_w = comb_f_r.near_t[DSW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= comb_f_r.valid;
      hit_r       <= !miss_w;
      dist_r      <= miss_w ? '0 : dist_w;
      // Entering through the low plane (negative face) when direction is positive.
      face_r      <= miss_w ? 3'(0) : {comb_f_r.axis, comb_f_r.dpos[comb_f_r.axis]};
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = hit_r;
  assign out_ch.entry_distance = dist_r;
  assign out_ch.entry_face     = face_r;

endmodule

### rtl/rbs_checker.sv
// Port level checks for ray_box_slab_entry, attached by bind.
// Depends on ray_box_slab_entry_defines.svh and rbs_pkg.
`include "ray_box_slab_entry_defines.svh"

module rbs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic [rbs_pkg::DIST_W-1:0]  entry_distance,
  input logic [rbs_pkg::FACE_W-1:0]  entry_face
);

  `RBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `RBS_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready, "input blocked with free output")
  `RBS_ASSERT_IMP(a_miss_zero, out_valid && !hit, entry_distance == '0 && entry_face == '0, "miss with nonzero fields")
  `RBS_ASSERT_IMP(a_face_range, out_valid && hit, entry_face <= 3'd5, "entry face out of range")

endmodule

bind ray_box_slab_entry rbs_checker u_rbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .hit            (out_ch.hit),
  .entry_distance (out_ch.entry_distance),
  .entry_face     (out_ch.entry_face)
);

### test/rbs_slab_checker.sv
// Scoreboard for the ray versus box slab test: watches both channels,
// predicts each result and compares it. Depends on rbs_pkg and rbs_ifs.
module rbs_slab_checker (
  input  logic clk,
  input  logic rst_n,
  rbs_in_if    in_ch,
  rbs_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   hits,
  output int   misses
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC     = 16;
  localparam longint DIST_TOP = (longint'(1) << rbs_pkg::DIST_W) - 1;

  typedef struct packed {
    logic                         hit;
    logic [rbs_pkg::DIST_W-1:0]   entry_dist;
    logic [rbs_pkg::FACE_W-1:0]   face;
  } slab_hit_t;

  slab_hit_t expected_hits[$];

  function automatic slab_hit_t slab_intersect(input longint lo[3], input longint hi[3],
                                               input longint org[3], input longint dir[3]);
    slab_hit_t r;
    longint t_in, t_out, near_t, far_t, tmp;
    bit     have_near, have_far, missed;
    int     near_axis;
    r = '0;
    near_t = 0; far_t = 0; have_near = 0; have_far = 0; missed = 0; near_axis = 0;
    for (int a = 0; a < 3; a++) begin
      if (missed) continue;
      if (dir[a] == 0) begin
        // flat axis: origin must lie inside that slab
        if (org[a] < lo[a] || org[a] > hi[a]) missed = 1;
        continue;
      end
      t_in  = ((lo[a] - org[a]) <<< FRAC) / dir[a];
      t_out = ((hi[a] - org[a]) <<< FRAC) / dir[a];
      if (t_in > t_out) begin
        tmp = t_in; t_in = t_out; t_out = tmp;
      end
      if (!have_near || t_in > near_t) begin
        near_t = t_in; near_axis = a; have_near = 1;
      end
      if (!have_far || t_out < far_t) begin
        far_t = t_out; have_far = 1;
      end
      if (near_t > far_t) missed = 1;
    end
    if (missed || !have_near || far_t < 0) return r;
    if (near_t < 0) near_t = 0;
    if (near_t > DIST_TOP) near_t = DIST_TOP;
    r.hit        = 1'b1;
    r.entry_dist = near_t[rbs_pkg::DIST_W-1:0];
    r.face       = 3'(2 * near_axis + (dir[near_axis] > 0 ? 1 : 0));
    return r;
  endfunction

  initial begin
    errors = 0; pending = 0; hits = 0; misses = 0;
  end

  always @(posedge clk) begin
    longint    lo[3], hi[3], org[3], dir[3];
    slab_hit_t want, got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      lo  = '{longint'(in_ch.box_low_x),  longint'(in_ch.box_low_y),  longint'(in_ch.box_low_z)};
      hi  = '{longint'(in_ch.box_high_x), longint'(in_ch.box_high_y), longint'(in_ch.box_high_z)};
      org = '{longint'(in_ch.origin_x),   longint'(in_ch.origin_y),   longint'(in_ch.origin_z)};
      dir = '{longint'(in_ch.dir_x),      longint'(in_ch.dir_y),      longint'(in_ch.dir_z)};
      expected_hits.push_back(slab_intersect(lo, hi, org, dir));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.hit, out_ch.entry_distance, out_ch.entry_face};
      if (expected_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0b dist=%0d face=%0d",
                                   got.hit, got.entry_dist, got.face);
      end else begin
        want = expected_hits.pop_front();
        if (want.hit) hits++; else misses++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want hit=%0b dist=%0d face=%0d, got hit=%0b dist=%0d face=%0d",
                     want.hit, want.entry_dist, want.face, got.hit, got.entry_dist, got.face);
        end
      end
    end
    pending <= expected_hits.size();
  end
endmodule

### test/tb_ray_box_slab_entry.sv
// Top of the slab test bench: clock, reset, directed and random rays,
// idling on both channels. Depends on rbs_pkg, rbs_ifs, the block and rbs_slab_checker.
module tb_ray_box_slab_entry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint U      = 64'd65536;                 // 1.0 in Q.16
  localparam longint POSMAX = (longint'(1) << 36) - 1;
  localparam longint POSMIN = -(longint'(1) << 36);
  localparam longint DMAX   = 131071;
  localparam longint DMIN   = -131072;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, pending, hits, misses;
  int   sent = 0;
  int   results = 0;
  bit   calm = 0;       // when set, neither side inserts random idle gaps

  rbs_in_if  in_ch();
  rbs_out_if out_ch();

  ray_box_slab_entry uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rbs_slab_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                        .errors(errors), .pending(pending), .hits(hits), .misses(misses));

  always #6 clk = ~clk;

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6ms;
    $display("tb_ray_box_slab_entry: FAIL");
    $finish;
  end

  // Count taken results in a process of their own; the long hold-off keys on it.
  always @(posedge clk) if (rst_n && out_ch.valid && out_ch.ready) results++;

  // Receiver: a random wait before each result, plus one long stall so the
  // pipeline fills and the input side backs up.
  initial begin
    int  w;
    bit  held = 0;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (!held && results >= 120) begin
        held = 1;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      w = calm ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_ch.ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic longint rnd_pos();
    logic [36:0] v;
    v = 37'({$urandom, $urandom});
    return longint'($signed(v));
  endfunction

  function automatic longint rnd_dir();
    logic [17:0] v;
    v = 18'($urandom);
    return longint'($signed(v));
  endfunction

  // Offer one ray; returns once it has been taken.
  task automatic send_ray(input longint lx, ly, lz, hx, hy, hz,
                          input longint ox, oy, oz, dx, dy, dz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.box_low_x  = 37'(lx); in_ch.box_low_y  = 37'(ly); in_ch.box_low_z  = 37'(lz);
    in_ch.box_high_x = 37'(hx); in_ch.box_high_y = 37'(hy); in_ch.box_high_z = 37'(hz);
    in_ch.origin_x   = 37'(ox); in_ch.origin_y   = 37'(oy); in_ch.origin_z   = 37'(oz);
    in_ch.dir_x      = 18'(dx); in_ch.dir_y      = 18'(dy); in_ch.dir_z      = 18'(dz);
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // A box near a random center, origin close by, direction mostly aimed at it.
  task automatic send_shaped_ray();
    longint c[3], h[3], o[3], d[3], t;
    for (int a = 0; a < 3; a++) begin
      c[a] = longint'($signed(32'($urandom))) >>> 2;
      h[a] = longint'($urandom_range(1, 1 << 24));
      o[a] = c[a] + (longint'($signed(32'($urandom))) >>> ($urandom_range(4, 8)));
      case ($urandom_range(0, 7))
        0:       d[a] = 0;
        1:       d[a] = $urandom_range(0, 1) ? DMAX : DMIN;
        2:       d[a] = longint'($urandom_range(1, 16)) * ($urandom_range(0, 1) ? 1 : -1);
        default: d[a] = (c[a] - o[a]) >>> 14;   // roughly toward the box center
      endcase
      if (d[a] > DMAX) d[a] = DMAX;
      if (d[a] < DMIN) d[a] = DMIN;
    end
    if ($urandom_range(0, 9) == 0) begin       // occasionally an inverted box on x
      t = h[0]; h[0] = -t;
    end
    send_ray(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2],
             o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.box_low_x = '0; in_ch.box_low_y = '0; in_ch.box_low_z = '0;
    in_ch.box_high_x = '0; in_ch.box_high_y = '0; in_ch.box_high_z = '0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed part.
    // straight hits through each face, both senses
    send_ray(10*U, -U, -U, 12*U, U, U, 0, 0, 0, U, 0, 0);
    send_ray(10*U, -U, -U, 12*U, U, U, 20*U, 0, 0, -U, 0, 0);
    send_ray(-U, 10*U, -U, U, 12*U, U, 0, 0, 0, 0, U, 0);
    send_ray(-U, 10*U, -U, U, 12*U, U, 0, 20*U, 0, 0, -U, 0);
    send_ray(-U, -U, 10*U, U, U, 12*U, 0, 0, 0, 0, 0, U);
    send_ray(-U, -U, 10*U, U, U, 12*U, 0, 0, 20*U, 0, 0, -U);
    // origin inside the box: distance clamps to zero
    send_ray(-U, -U, -U, U, U, U, 0, 0, 0, U/2, -U/3, U/5);
    // box entirely behind the origin
    send_ray(-12*U, -U, -U, -10*U, U, U, 0, 0, 0, U, 0, 0);
    // flat axis with origin outside its slab, and on its boundary
    send_ray(10*U, -U, -U, 12*U, U, U, 0, 5*U, 0, U, 0, 0);
    send_ray(10*U, -U, -U, 12*U, U, U, 0, U, -U, U, 0, 0);
    // no usable axis at all
    send_ray(-U, -U, -U, U, U, U, 0, 0, 0, 0, 0, 0);
    // inverted box on x
    send_ray(12*U, -U, -U, 10*U, U, U, 0, 0, 0, U, 0, 0);
    // entry and exit cross: diagonal ray past an off-axis box
    send_ray(10*U, -12*U, -U, 11*U, -10*U, U, 0, 0, 0, U, U, 0);
    // tie on all three axes keeps the first axis
    send_ray(5*U, 5*U, 5*U, 6*U, 6*U, 6*U, 0, 0, 0, U, U, U);
    // distance beyond range saturates
    send_ray(POSMAX - 4, -U, -U, POSMAX, U, U, POSMIN, 0, 0, 1, 0, 0);
    // extreme bounds and directions
    send_ray(POSMIN, POSMIN, POSMIN, POSMAX, POSMAX, POSMAX, 0, 0, 0, DMAX, DMIN, DMAX);
    send_ray(POSMIN, POSMIN, POSMIN, POSMAX, POSMAX, POSMAX,
             POSMAX, POSMIN, POSMAX, DMIN, DMAX, -1);
    send_ray(POSMAX, POSMAX, POSMAX, POSMAX, POSMAX, POSMAX,
             POSMIN, POSMIN, POSMIN, DMAX, DMAX, DMAX);
    send_ray(POSMIN, POSMIN, POSMIN, POSMIN, POSMIN, POSMIN,
             POSMAX, POSMAX, POSMAX, DMIN, DMIN, DMIN);

    // Random part: shaped rays mostly, full-range noise the rest.
    for (int i = 0; i < 700; i++) begin
      calm = ((i / 90) % 3) == 2;
      if ($urandom_range(0, 3) == 0)
        send_ray(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(),
                 rnd_pos(), rnd_pos(), rnd_pos(), rnd_dir(), rnd_dir(), rnd_dir());
      else
        send_shaped_ray();
    end
    @(negedge clk) in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);   // catch stray results from the pipeline

    $display("%0d rays sent, %0d hits and %0d misses checked", sent, hits, misses);
    if (errors == 0)
      $display("tb_ray_box_slab_entry: PASS");
    else
      $display("tb_ray_box_slab_entry: FAIL");
    $finish;
  end
endmodule

### ray_box_slab_entry.f
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_ifs.sv
rtl/ray_box_slab_entry.sv
rtl/rbs_checker.sv
test/rbs_slab_checker.sv
test/tb_ray_box_slab_entry.sv
